/* src/tsol_pkg.sv */
package tsol_pkg;

  // List geometry
  localparam int LIST_DEPTH = 16;
  localparam int DATA_W     = 32;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Port field widths
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT_END   = 2'd0,
    FUNC_INSERT_FRONT = 2'd1,
    FUNC_DELETE_FRONT = 2'd2,
    FUNC_SEARCH       = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SWAP_PRED,
    ST_SWAP_HIT,
    ST_RESP
  } state_t;

  // Map a logical list position onto the circular buffer
  function automatic logic [IDX_W-1:0] phys_index(input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] logical);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, logical};
    if (sum >= (IDX_W+1)'(LIST_DEPTH)) begin
      sum = sum - (IDX_W+1)'(LIST_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* src/tsol_ram.sv */
module tsol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* src/transpose_self_organizing_list_core.sv */
// Channel  Handshake            Payload
// input    in_valid / in_stall  func, value
// output   out_valid / out_stall status, found_position, entry_count
//
// One transaction at a time. Inserts and delete front need no scan.
// A search reads one entry per cycle from the list memory: a hit at position 0
// responds directly, a later hit swaps with its predecessor in ST_SWAP_PRED and
// ST_SWAP_HIT, a miss ends after the last entry, an empty list skips the scan.
// The list is a circular buffer, so front operations never move entries.
// Synchronous reset empties the list; memory contents stay undefined.
// A stalled output holds the block in its response state until it is taken.
module transpose_self_organizing_list_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tsol_pkg::FUNC_W-1:0]   func,
  input  logic signed [tsol_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsol_pkg::STATUS_W-1:0] status,
  output logic [tsol_pkg::POS_W-1:0]    found_position,
  output logic [tsol_pkg::COUNT_W-1:0]  entry_count
);

  localparam int IDX_W  = tsol_pkg::IDX_W;
  localparam int CNT_W  = tsol_pkg::CNT_W;
  localparam int DATA_W = tsol_pkg::DATA_W;

  tsol_pkg::state_t  state, state_next;
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  occ;
  logic [DATA_W-1:0] key;
  logic [CNT_W-1:0]  issue_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [DATA_W-1:0] prev;
  logic [IDX_W-1:0]  hit_idx;
  tsol_pkg::status_t res_status;
  logic [IDX_W-1:0]  res_pos;

  logic              accept;
  logic              full;
  logic              empty;
  logic              rd_issue;
  logic              match;
  logic              miss_done;
  logic              resp_free;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  head_dec;
  tsol_pkg::func_t   in_func;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  logic [tsol_pkg::POS_W+IDX_W-1:0]   pos_ext;
  logic [tsol_pkg::COUNT_W+CNT_W-1:0] count_ext;

  tsol_ram #(
    .WIDTH (DATA_W),
    .DEPTH (tsol_pkg::LIST_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status decode
  assign in_func   = tsol_pkg::func_t'(func);
  assign accept    = in_valid && !in_stall;
  assign full      = (occ == CNT_W'(tsol_pkg::LIST_DEPTH));
  assign empty     = (occ == '0);
  assign head_inc  = (head == IDX_W'(tsol_pkg::LIST_DEPTH - 1)) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? IDX_W'(tsol_pkg::LIST_DEPTH - 1) : head - 1'b1;
  assign rd_issue  = (state == tsol_pkg::ST_SCAN) && (issue_idx < occ);
  assign match     = cmp_valid && (rdata == key);
  assign miss_done = cmp_valid && !match && ((CNT_W'(cmp_idx) + CNT_W'(1)) == occ);
  assign resp_free = !out_valid || !out_stall;
  assign raddr     = tsol_pkg::phys_index(head, issue_idx[IDX_W-1:0]);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tsol_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_func == tsol_pkg::FUNC_SEARCH && !empty) begin
            state_next = tsol_pkg::ST_SCAN;
          end else begin
            state_next = tsol_pkg::ST_RESP;
          end
        end
      end
      tsol_pkg::ST_SCAN: begin
        if (match) begin
          state_next = (cmp_idx == '0) ? tsol_pkg::ST_RESP : tsol_pkg::ST_SWAP_PRED;
        end else if (miss_done) begin
          state_next = tsol_pkg::ST_RESP;
        end
      end
      tsol_pkg::ST_SWAP_PRED: state_next = tsol_pkg::ST_SWAP_HIT;
      tsol_pkg::ST_SWAP_HIT:  state_next = tsol_pkg::ST_RESP;
      tsol_pkg::ST_RESP: begin
        if (resp_free) begin
          state_next = tsol_pkg::ST_IDLE;
        end
      end
      default: state_next = tsol_pkg::ST_IDLE;
    endcase
  end

  // Memory write port and input stall
  always_comb begin
    in_stall = 1'b1;
    we       = 1'b0;
    waddr    = head;
    wdata    = value;
    unique case (state)
      tsol_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (accept && !full) begin
          if (in_func == tsol_pkg::FUNC_INSERT_END) begin
            we    = 1'b1;
            waddr = tsol_pkg::phys_index(head, occ[IDX_W-1:0]);
          end else if (in_func == tsol_pkg::FUNC_INSERT_FRONT) begin
            we    = 1'b1;
            waddr = head_dec;
          end
        end
      end
      tsol_pkg::ST_SWAP_PRED: begin
        we    = 1'b1;
        waddr = tsol_pkg::phys_index(head, hit_idx - 1'b1);
        wdata = key;
      end
      tsol_pkg::ST_SWAP_HIT: begin
        we    = 1'b1;
        waddr = tsol_pkg::phys_index(head, hit_idx);
        wdata = prev;
      end
      tsol_pkg::ST_SCAN, tsol_pkg::ST_RESP: begin
        we = 1'b0;
      end
      default: we = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsol_pkg::ST_IDLE;
      head      <= '0;
      occ       <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && !full && (in_func == tsol_pkg::FUNC_INSERT_END ||
                              in_func == tsol_pkg::FUNC_INSERT_FRONT)) begin
        occ <= occ + 1'b1;
        if (in_func == tsol_pkg::FUNC_INSERT_FRONT) begin
          head <= head_dec;
        end
      end else if (accept && !empty && in_func == tsol_pkg::FUNC_DELETE_FRONT) begin
        occ  <= occ - 1'b1;
        head <= head_inc;
      end
      // Read pipeline tag: a compare follows each issued read
      cmp_valid <= rd_issue;
      // Present the finished transaction, drop it once taken
      if (state == tsol_pkg::ST_RESP && resp_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= value;
      res_pos   <= '0;
      issue_idx <= '0;
      case (in_func)
        tsol_pkg::FUNC_INSERT_END, tsol_pkg::FUNC_INSERT_FRONT:
          res_status <= full ? tsol_pkg::STATUS_FULL : tsol_pkg::STATUS_OK;
        tsol_pkg::FUNC_DELETE_FRONT:
          res_status <= empty ? tsol_pkg::STATUS_EMPTY : tsol_pkg::STATUS_OK;
        default:
          res_status <= tsol_pkg::STATUS_NOT_FOUND;
      endcase
    end
    if (state == tsol_pkg::ST_SCAN) begin
      if (rd_issue) begin
        issue_idx <= issue_idx + 1'b1;
      end
      cmp_idx <= issue_idx[IDX_W-1:0];
      // Keep the predecessor of the next compare
      if (cmp_valid && !match) begin
        prev <= rdata;
      end
      if (match) begin
        res_status <= tsol_pkg::STATUS_OK;
        res_pos    <= cmp_idx;
        hit_idx    <= cmp_idx;
      end
    end
    if (state == tsol_pkg::ST_RESP && resp_free) begin
      status         <= res_status;
      found_position <= pos_ext[tsol_pkg::POS_W-1:0];
      entry_count    <= count_ext[tsol_pkg::COUNT_W-1:0];
    end
  end

  assign pos_ext   = {tsol_pkg::POS_W'(0), res_pos};
  assign count_ext = {tsol_pkg::COUNT_W'(0), occ};

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(tsol_pkg::LIST_DEPTH))
    else $error("occupancy above list depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !full && in_func == tsol_pkg::FUNC_INSERT_END |=> occ == $past(occ) + 1'b1)
    else $error("insert did not grow the list");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == tsol_pkg::ST_SCAN |-> !we)
    else $error("memory written during search scan");

  a_pos_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_position != '0 |-> status == tsol_pkg::STATUS_OK)
    else $error("found position reported without a hit");

  a_swap_follows_pred: assert property (@(posedge clk) disable iff (rst)
    state == tsol_pkg::ST_SWAP_PRED |=> state == tsol_pkg::ST_SWAP_HIT)
    else $error("swap writeback broken");

endmodule
